### design/mlps_pkg.sv
// Shared constants, types and activation tables for the perceptron scorer.
package mlps_pkg;

  localparam int DEF_N_INPUTS = 64;
  localparam int DEF_N_HIDDEN = 25;

  localparam logic [2:0] OP_HWEIGHT = 3'd0;
  localparam logic [2:0] OP_HBIAS   = 3'd1;
  localparam logic [2:0] OP_OWEIGHT = 3'd2;
  localparam logic [2:0] OP_FEATURE = 3'd4;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_OUT_BIAS  = 1'b1;

  localparam logic [63:0] EXP_STEP = 64'd4034748382;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;

  typedef logic [32:0] exp_rom_t [0:256];
  typedef logic [16:0] act_rom_t [0:256];

  // Control for one cell of the hidden-neuron ring.
  typedef struct packed {
    logic shift;
    logic bias_we;
    logic ow_we;
  } cell_ctrl_t;

  // Restoring division, evaluated only while the tables are built.
  function automatic logic [63:0] div_long(logic [63:0] n, logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Samples of exp(-k/16) in Q32.
  function automatic exp_rom_t build_exp();
    exp_rom_t x;
    logic [65:0] p;
    x[0] = ONE_Q32[32:0];
    for (int i = 1; i < 257; i++) begin
      p = 66'(x[i-1]) * 66'(EXP_STEP) + 66'(ONE_Q32 >> 1);
      x[i] = p[64:32];
    end
    return x;
  endfunction

  function automatic act_rom_t build_sig();
    exp_rom_t ex;
    act_rom_t t;
    logic [63:0] s;
    int m;
    ex = build_exp();
    for (int i = 0; i < 257; i++) begin
      m = (i < 128) ? 128 - i : i - 128;
      s = div_long(ONE_Q32 << 16, ONE_Q32 + 64'(ex[m]));
      t[i] = (i < 128) ? 17'(64'd65536 - s) : s[16:0];
    end
    return t;
  endfunction

  // tanh samples, stored offset by one in Q5.12.
  function automatic act_rom_t build_tanh();
    exp_rom_t ex;
    act_rom_t t;
    logic [63:0] mag;
    int m;
    ex = build_exp();
    for (int i = 0; i < 257; i++) begin
      m = (i < 128) ? 128 - i : i - 128;
      mag = div_long((ONE_Q32 - 64'(ex[2*m])) << 12, ONE_Q32 + 64'(ex[2*m]));
      t[i] = (i < 128) ? 17'(64'd4096 - mag) : 17'(64'd4096 + mag);
    end
    return t;
  endfunction

  localparam act_rom_t SIG_ROM  = build_sig();
  localparam act_rom_t TANH_ROM = build_tanh();

  // Linear interpolation between neighboring samples, floored.
  function automatic logic [16:0] rom_interp(logic [16:0] lo, logic [16:0] hi,
                                             logic [7:0] f);
    logic [26:0] p;
    p = 27'(lo) * 27'(9'd256 - {1'b0, f}) + 27'(hi) * 27'(f);
    return p[24:8];
  endfunction

endpackage

### design/mlps_cell.sv
// One hidden neuron slot of the ring: running sum, bias and output weight.
module mlps_cell (
  input  logic                clk,
  input  logic                rst,
  input  mlps_pkg::cell_ctrl_t ctrl,
  input  logic signed [15:0]  wr_value,
  input  logic signed [39:0]  sum_in,
  input  logic signed [15:0]  bias_in,
  input  logic signed [15:0]  ow_in,
  output logic signed [39:0]  sum,
  output logic signed [15:0]  bias,
  output logic signed [15:0]  ow
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.shift) begin
      sum <= sum_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bias_we) begin
      bias <= wr_value;
    end else if (ctrl.shift) begin
      bias <= bias_in;
    end
    if (ctrl.ow_we) begin
      ow <= wr_value;
    end else if (ctrl.shift) begin
      ow <= ow_in;
    end
  end

endmodule

### design/mlp_tansig_logsig_scorer_unit.sv
// Top level of the perceptron scorer: weight memory, neuron ring and output neuron.
//
//   channel  signals                          payload
//   s_*      s_tvalid s_tready s_tdata s_tuser s_tlast  loads and feature values
//   m_*      m_tvalid m_tready m_tdata m_tuser          one score per pattern
//   cfg_*    cfg_valid cfg_ready cfg_index cfg_data     threshold, output bias
//
// A load is taken whenever the unit is idle. A feature value rotates the ring of
// hidden sums once past the single multiply-accumulate, one weight read a cycle, and
// intake stops meanwhile. The last feature adds the tanh pass and the output neuron.
// Reset clears the sums, position and pattern count; the weight stores start undefined.
// A held result stalls only the next score; intake stops while that next score waits.
module mlp_tansig_logsig_scorer_unit #(
  parameter int N_INPUTS = mlps_pkg::DEF_N_INPUTS,
  parameter int N_HIDDEN = mlps_pkg::DEF_N_HIDDEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // hidden_index[4:0], feature_index[10:5], value[26:11]
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pattern_number[15:0], score[31:16]
  output logic        m_tuser,   // above_threshold[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int DEPTH = N_HIDDEN * N_INPUTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(N_INPUTS + 1);
  localparam int KW    = $clog2(N_HIDDEN + 1);
  localparam int ACC_W = 31 + $clog2(N_HIDDEN + 1);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_FIN, S_DRAIN, S_OUT1, S_OUT2} state_t;

  function automatic logic signed [15:0] sat16(logic signed [ACC_W:0] v);
    if (v > $signed((ACC_W+1)'(32767))) return 16'sh7FFF;
    if (v < -$signed((ACC_W+1)'(32768))) return 16'sh8000;
    return v[15:0];
  endfunction

  state_t state;
  logic [KW-1:0] k;
  logic [PW-1:0] pos;
  logic [15:0] patterns;
  logic [15:0] threshold;
  logic signed [15:0] out_bias;
  logic signed [15:0] val;
  logic [AW-1:0] base;
  logic signed [15:0] rdata;
  logic signed [15:0] mem [DEPTH];
  logic s_tlast_l;

  logic [2:0] opcode;
  logic [4:0] hi;
  logic [5:0] fi;
  logic signed [15:0] value;
  logic accept, feat_acc;
  logic hi_ok, fi_ok;
  logic [AW-1:0] wr_addr, start_addr;

  assign opcode   = s_tuser;
  assign hi       = s_tdata[4:0];
  assign fi       = s_tdata[10:5];
  assign value    = s_tdata[26:11];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign feat_acc = accept && (opcode == mlps_pkg::OP_FEATURE);
  assign hi_ok    = 32'(hi) < 32'(N_HIDDEN);
  assign fi_ok    = 32'(fi) < 32'(N_INPUTS);
  assign wr_addr  = AW'(32'(hi) * 32'(N_INPUTS) + 32'(fi));
  assign start_addr = AW'(32'(N_HIDDEN - 1) * 32'(N_INPUTS) + 32'(pos));

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd32768;
      out_bias  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mlps_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        mlps_pkg::CFG_OUT_BIAS:  out_bias  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hidden weight memory: one write port for loads, one registered read.
  always_ff @(posedge clk) begin
    if (accept && opcode == mlps_pkg::OP_HWEIGHT && hi_ok && fi_ok) begin
      mem[wr_addr] <= value;
    end
    if (state == S_MAC) begin
      rdata <= mem[AW'(base - AW'(N_INPUTS))];
    end else begin
      rdata <= mem[start_addr];
    end
  end

  // Ring of hidden neurons; the head cell feeds cell 0 through the MAC.
  logic signed [39:0] c_sum  [N_HIDDEN];
  logic signed [15:0] c_bias [N_HIDDEN];
  logic signed [15:0] c_ow   [N_HIDDEN];
  logic signed [39:0] feed_sum;
  logic signed [31:0] prod;
  logic signed [40:0] mac;
  logic shift;

  assign shift = (state == S_MAC) || (state == S_FIN);
  assign prod  = val * rdata;
  assign mac   = {c_sum[N_HIDDEN-1][39], c_sum[N_HIDDEN-1]} + 41'(prod);

  always_comb begin
    if (state != S_MAC) begin
      feed_sum = '0;
    end else if (mac > $signed({2'b00, {39{1'b1}}})) begin
      feed_sum = {1'b0, {39{1'b1}}};
    end else if (mac < $signed({2'b11, {39{1'b0}}})) begin
      feed_sum = {1'b1, {39{1'b0}}};
    end else begin
      feed_sum = mac[39:0];
    end
  end

  for (genvar i = 0; i < N_HIDDEN; i++) begin : g_cell
    mlps_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift   = shift;
    assign ctrl.bias_we = accept && opcode == mlps_pkg::OP_HBIAS && 32'(hi) == i;
    assign ctrl.ow_we   = accept && opcode == mlps_pkg::OP_OWEIGHT && 32'(hi) == i;
    mlps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_value (value),
      .sum_in   ((i == 0) ? feed_sum : c_sum[(i == 0) ? 0 : i-1]),
      .bias_in  (c_bias[(i == 0) ? N_HIDDEN-1 : i-1]),
      .ow_in    (c_ow[(i == 0) ? N_HIDDEN-1 : i-1]),
      .sum      (c_sum[i]),
      .bias     (c_bias[i]),
      .ow       (c_ow[i])
    );
  end

  // Output neuron pipeline: argument, tanh, weighted accumulate, then bias and sigmoid.
  logic a_v, b_v;
  logic signed [15:0] a_arg, a_ow, b_ow, o_arg;
  logic signed [14:0] b_t;
  logic signed [ACC_W-1:0] acc;
  logic [15:0] ua, uo;
  logic [16:0] t_raw, s_raw;
  logic signed [30:0] tw;
  logic signed [28:0] hsum_sh;

  assign hsum_sh = 29'(c_sum[N_HIDDEN-1] >>> 12) + 29'(c_bias[N_HIDDEN-1]);
  assign ua    = {~a_arg[15], a_arg[14:0]};
  assign t_raw = mlps_pkg::rom_interp(mlps_pkg::TANH_ROM[ua[15:8]],
                   mlps_pkg::TANH_ROM[{1'b0, ua[15:8]} + 9'd1], ua[7:0]);
  assign tw    = b_t * b_ow;
  assign uo    = {~o_arg[15], o_arg[14:0]};
  assign s_raw = mlps_pkg::rom_interp(mlps_pkg::SIG_ROM[uo[15:8]],
                   mlps_pkg::SIG_ROM[{1'b0, uo[15:8]} + 9'd1], uo[7:0]);

  always_ff @(posedge clk) begin
    a_arg <= sat16((ACC_W+1)'(hsum_sh));
    a_ow  <= c_ow[N_HIDDEN-1];
    b_t   <= $signed({1'b0, t_raw[13:0]}) - 15'sd4096;
    b_ow  <= a_ow;
    o_arg <= sat16((ACC_W+1)'(acc >>> 12) + (ACC_W+1)'(out_bias));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      k        <= '0;
      pos      <= '0;
      patterns <= '0;
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      acc      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      a_v <= (state == S_FIN);
      b_v <= a_v;
      if (b_v) begin
        acc <= acc + ACC_W'(tw);
      end
      if (m_tvalid && m_tready && state != S_OUT2) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (feat_acc) begin
            val  <= value;
            base <= start_addr;
            k    <= '0;
            acc  <= '0;
            if (32'(pos) < 32'(N_INPUTS)) begin
              state <= S_MAC;
            end else if (s_tlast) begin
              state <= S_FIN;
            end
          end
        end
        S_MAC: begin
          base <= AW'(base - AW'(N_INPUTS));
          if (32'(k) == N_HIDDEN - 1) begin
            k     <= '0;
            pos   <= pos + PW'(1);
            state <= s_tlast_l ? S_FIN : S_IDLE;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_FIN: begin
          if (32'(k) == N_HIDDEN - 1) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_DRAIN: begin
          if (!a_v && !b_v) begin
            state <= S_OUT1;
          end
        end
        S_OUT1: state <= S_OUT2;
        S_OUT2: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata[15:0]  <= patterns + 16'd1;
            m_tdata[31:16] <= s_raw[16] ? 16'hFFFF : s_raw[15:0];
            m_tuser  <= (s_raw[16] ? 16'hFFFF : s_raw[15:0]) >= threshold;
            patterns <= patterns + 16'd1;
            pos      <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Last flag of the feature transaction being accumulated.
  always_ff @(posedge clk) begin
    if (feat_acc) begin
      s_tlast_l <= s_tlast;
    end
  end

endmodule
